// File: sv/cam_pkg.sv
// ----------------------------------------------------------------------------
// cam_pkg
// shared types and codes of the cdr aligned marshaller
// ----------------------------------------------------------------------------
package cam_pkg;

   // command codes of the request beat
   localparam logic [2:0] OP_BYTE     = 3'd0;
   localparam logic [2:0] OP_BOOL     = 3'd1;
   localparam logic [2:0] OP_SHORT    = 3'd2;
   localparam logic [2:0] OP_LONG     = 3'd3;
   localparam logic [2:0] OP_LONGLONG = 3'd4;
   localparam logic [2:0] OP_RESTART  = 3'd5;

   localparam int unsigned VALUE_WIDTH = 64;
   localparam int unsigned BYTE_WIDTH  = 8;

   typedef struct packed {
      logic [2:0]             cmd;
      logic [VALUE_WIDTH-1:0] value;
   } cam_req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  is_pad;
      logic                  last;
   } cam_rsp_type;

   typedef enum logic [1:0] {
      KIND_VALUE,
      KIND_RESTART,
      KIND_NONE
   } cam_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_DATA
   } cam_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic restart;
      logic emit_pad;
      logic emit_data;
   } cam_cmd_type;

   // datapath to controller
   typedef struct packed {
      cam_kind_type req_kind;
      logic         pad_needed;
      logic         pad_final;
      logic         data_final;
      logic         out_free;
   } cam_status_type;

endpackage

// File: sv/cam_stream_if.sv
// ----------------------------------------------------------------------------
// cam_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface cam_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/cam_datapath.sv
// ----------------------------------------------------------------------------
// cam_datapath
// offset tracking, pad count, byte shifter and output register
// ----------------------------------------------------------------------------
module cam_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  cam_pkg::cam_cmd_type    cmd,
   input  cam_pkg::cam_req_type    req_data,
   input  logic                    rsp_ready,
   output cam_pkg::cam_status_type status,
   output logic                    rsp_valid,
   output cam_pkg::cam_rsp_type    rsp_data
);
   import cam_pkg::*;

   logic [2:0]             offset_ff, offset_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cam_rsp_type            rsp_data_ff, rsp_data_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [2:0]             pad_cnt_ff, pad_cnt_in;
   logic [2:0]             byte_cnt_ff, byte_cnt_in;
   logic [2:0]             mask_ff, mask_in;

   logic [2:0]             size_mask;
   logic [2:0]             load_pad;
   cam_kind_type           req_kind;
   logic [VALUE_WIDTH-1:0] aligned;

   // decode of the request beat
   always_comb begin
      size_mask = 3'd0;
      req_kind  = KIND_NONE;
      aligned   = req_data.value;
      unique case (req_data.cmd)
         OP_BYTE: begin
            req_kind = KIND_VALUE;
            aligned  = {req_data.value[7:0], 56'd0};
         end
         OP_BOOL: begin
            req_kind = KIND_VALUE;
            aligned  = {7'd0, |req_data.value[7:0], 56'd0};
         end
         OP_SHORT: begin
            req_kind  = KIND_VALUE;
            size_mask = 3'd1;
            aligned   = {req_data.value[15:0], 48'd0};
         end
         OP_LONG: begin
            req_kind  = KIND_VALUE;
            size_mask = 3'd3;
            aligned   = {req_data.value[31:0], 32'd0};
         end
         OP_LONGLONG: begin
            req_kind  = KIND_VALUE;
            size_mask = 3'd7;
         end
         OP_RESTART: begin
            req_kind = KIND_RESTART;
         end
         default: begin
            req_kind = KIND_NONE;
         end
      endcase
   end

   // bytes up to the next multiple of the size
   assign load_pad = (3'd0 - offset_ff) & size_mask;

   assign status.req_kind   = req_kind;
   assign status.pad_needed = (load_pad != 3'd0);
   assign status.pad_final  = (pad_cnt_ff == 3'd1);
   assign status.data_final = (byte_cnt_ff == 3'd0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      shift_in     = shift_ff;
      pad_cnt_in   = pad_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      mask_in      = mask_ff;
      if (cmd.load) begin
         shift_in    = aligned;
         pad_cnt_in  = load_pad;
         byte_cnt_in = size_mask;
         mask_in     = size_mask;
      end
      if (cmd.restart) begin
         offset_in = 3'd0;
      end
      if (cmd.emit_pad) begin
         offset_in            = offset_ff + 3'd1;
         pad_cnt_in           = pad_cnt_ff - 3'd1;
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = '0;
         rsp_data_in.is_pad   = 1'b1;
         rsp_data_in.last     = 1'b0;
      end
      if (cmd.emit_data) begin
         offset_in            = offset_ff + 3'd1;
         byte_cnt_in          = byte_cnt_ff - 3'd1;
         shift_in             = {shift_ff[VALUE_WIDTH-BYTE_WIDTH-1:0], {BYTE_WIDTH{1'b0}}};
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = shift_ff[VALUE_WIDTH-1 -: BYTE_WIDTH];
         rsp_data_in.is_pad   = 1'b0;
         rsp_data_in.last     = (byte_cnt_ff == 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      shift_ff    <= shift_in;
      pad_cnt_ff  <= pad_cnt_in;
      byte_cnt_ff <= byte_cnt_in;
      mask_ff     <= mask_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // never overwrite a result beat that is still waiting
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pad || cmd.emit_data) |-> (!rsp_valid_ff || rsp_ready))
      else $error("emit while output register busy");

   // a pad beat is only issued while pad bytes remain
   a_pad_count_left: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_pad |-> (pad_cnt_ff != 3'd0))
      else $error("pad beat with no pad left");

   // after the final value byte the offset is a multiple of the size
   a_aligned_after_value: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_data && (byte_cnt_ff == 3'd0)) |=> ((offset_ff & mask_ff) == 3'd0))
      else $error("stream offset misaligned after value");

endmodule

// File: sv/cam_ctrl.sv
// ----------------------------------------------------------------------------
// cam_ctrl
// sequencer stepping through pad and value bytes of one request
// ----------------------------------------------------------------------------
module cam_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cam_pkg::cam_status_type status,
   output cam_pkg::cam_cmd_type    cmd
);
   import cam_pkg::*;

   cam_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.restart   = 1'b0;
      cmd.emit_pad  = 1'b0;
      cmd.emit_data = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (status.req_kind)
                  KIND_VALUE: begin
                     cmd.load = 1'b1;
                     state_in = status.pad_needed ? ST_PAD : ST_DATA;
                  end
                  KIND_RESTART: begin
                     cmd.restart = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD: begin
            if (status.out_free) begin
               cmd.emit_pad = 1'b1;
               if (status.pad_final) begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (status.out_free) begin
               cmd.emit_data = 1'b1;
               if (status.data_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // requests are taken only between items
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.restart) |-> (state_ff == ST_IDLE))
      else $error("request taken mid item");

   // a value item always ends back in idle after its final byte
   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_data && status.data_final) |=> (state_ff == ST_IDLE))
      else $error("sequencer missed end of item");

endmodule

// File: sv/cdr_aligned_marshaller_top.sv
// ----------------------------------------------------------------------------
// cdr_aligned_marshaller_top
// big-endian cdr marshaller with natural alignment
// ----------------------------------------------------------------------------
// Each request beat carries a command and a 64-bit value. Bytes and booleans
// (nonzero low byte becomes 1) give one result beat; 2-, 4- and 8-byte values
// first give zero pad beats (is_pad set) until the running stream offset is a
// multiple of the size, then the value bytes most significant first, with
// last set on the final one. A restart command clears the offset and gives no
// result; unused command codes are dropped. The block takes one request,
// then sends one result beat per cycle while the output register is free: an
// item is accepted, then gives one beat per pad and value byte, stepped by
// the byte sequencer. Restart and unused commands end when they are accepted.
// A new request is accepted while the final result beat of the previous one
// still waits to be taken.
// ----------------------------------------------------------------------------
module cdr_aligned_marshaller_top (
   input  logic        clock,
   input  logic        reset,
   cam_stream_if.sink   req_chan,
   cam_stream_if.source rsp_chan
);
   import cam_pkg::*;

   cam_cmd_type    cmd;      // sequencer commands
   cam_status_type status;   // datapath status back to the sequencer
   logic           req_ready;
   logic           rsp_valid;
   cam_rsp_type    rsp_data;

   // sequencer: owns request handshake and byte stepping
   cam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: offset, pad count, shifter and output beat register
   cam_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_chan.data),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

endmodule

// File: sim/cdr_aligned_marshaller_checker.sv
// ----------------------------------------------------------------------------
// cdr_aligned_marshaller_checker
// watches both channels, predicts the byte stream and compares it beat by beat
// ----------------------------------------------------------------------------
module cdr_aligned_marshaller_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  cam_pkg::cam_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cam_pkg::cam_rsp_type rsp_data,
   output int                   error_count,
   output int                   pending_count,
   output int                   byte_count,
   output int                   pad_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import cam_pkg::*;

   cam_rsp_type expected_bytes[$];
   cam_rsp_type oldest;
   logic [2:0]  stream_offset;
   int          errors;
   int          bytes_seen;
   int          pads_seen;

   task automatic push_byte(input logic [7:0] value, input logic pad, input logic fin);
      cam_rsp_type beat;
      beat.out_byte = value;
      beat.is_pad   = pad;
      beat.last     = fin;
      expected_bytes.push_back(beat);
   endtask

   // serialize one request into the expected byte stream
   task automatic marshal_item(input cam_req_type req);
      int unsigned size;
      int unsigned pad;
      size = 0;
      case (req.cmd)
         OP_BYTE: begin
            push_byte(req.value[7:0], 1'b0, 1'b1);
            stream_offset = stream_offset + 3'd1;
         end
         OP_BOOL: begin
            push_byte((req.value[7:0] != 8'd0) ? 8'd1 : 8'd0, 1'b0, 1'b1);
            stream_offset = stream_offset + 3'd1;
         end
         OP_SHORT:    size = 2;
         OP_LONG:     size = 4;
         OP_LONGLONG: size = 8;
         OP_RESTART:  stream_offset = 3'd0;
         default: ;
      endcase
      if (size != 0) begin
         pad = (size - (stream_offset & (size - 1))) & (size - 1);
         for (int i = 0; i < pad; i++)
            push_byte(8'd0, 1'b1, 1'b0);
         for (int i = 0; i < size; i++)
            push_byte(8'(req.value >> (8 * (size - 1 - i))), 1'b0, i == size - 1);
         stream_offset = 3'(stream_offset + pad + size);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         stream_offset = 3'd0;
         errors        = 0;
         bytes_seen    = 0;
         pads_seen     = 0;
      end else begin
         // request first: its bytes go to the back, so the front stays the oldest
         if (req_valid && req_ready)
            marshal_item(req_data);
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (rsp_data.is_pad)
               pads_seen++;
            if (expected_bytes.size() == 0) begin
               $error("result beat with nothing expected: out_byte %0h is_pad %0b last %0b",
                      rsp_data.out_byte, rsp_data.is_pad, rsp_data.last);
               errors++;
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_data.out_byte !== oldest.out_byte) begin
                  $error("out_byte mismatch: expected %0h, actual %0h",
                         oldest.out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.is_pad !== oldest.is_pad) begin
                  $error("is_pad mismatch: expected %0b, actual %0b",
                         oldest.is_pad, rsp_data.is_pad);
                  errors++;
               end
               if (rsp_data.last !== oldest.last) begin
                  $error("last mismatch: expected %0b, actual %0b",
                         oldest.last, rsp_data.last);
                  errors++;
               end
            end
         end
      end
      error_count   <= errors;
      pending_count <= expected_bytes.size();
      byte_count    <= bytes_seen;
      pad_count     <= pads_seen;
   end

endmodule

// File: sim/cdr_aligned_marshaller_top_tb.sv
// ----------------------------------------------------------------------------
// cdr_aligned_marshaller_top_tb
// stimulus and verdict for the cdr aligned marshaller
// ----------------------------------------------------------------------------
// A directed run walks both byte values at their extremes, booleans with a
// zero and a nonzero low byte, every value size at aligned and misaligned
// offsets (up to seven pad bytes), restarts mid-stream and the two unused
// command codes. Random requests follow in four phases: no idling, sender
// idle, receiver stalling, and both. The checker beside the block predicts
// every result beat and counts mismatches; the sender drains the block at
// phase ends and now and then at random.
// ----------------------------------------------------------------------------
module cdr_aligned_marshaller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cam_pkg::*;

   // command codes the block must drop
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // worst case is far below this: ~140 requests with pads and stalls
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int idle_pct;
   int stall_pct;
   int cycle_count = 0;
   int items_sent;
   int unused_sent;
   int error_count;
   int pending_count;
   int byte_count;
   int pad_count;

   cam_stream_if #(.payload_type(cam_req_type)) req_chan ();
   cam_stream_if #(.payload_type(cam_rsp_type)) rsp_chan ();

   cdr_aligned_marshaller_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cdr_aligned_marshaller_checker checker_0 (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .byte_count    (byte_count),
      .pad_count     (pad_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: ready drawn fresh every cycle from the current stall rate
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result beats still expected",
                  cycle_count, pending_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(input logic [2:0] cmd, input logic [63:0] value);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data.cmd   <= cmd;
      req_chan.data.value <= value;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      items_sent++;
      if (cmd == OP_UNUSED_LO || cmd == OP_UNUSED_HI)
         unused_sent++;
   endtask

   // sender holds off until every predicted beat has come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [63:0] random_value();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random requests, mostly values of every size; unused codes are extra
   task automatic send_random(input int count);
      int          counted;
      int unsigned pick;
      logic [2:0]  cmd;
      logic [63:0] value;
      counted = 0;
      while (counted < count) begin
         pick  = $urandom_range(99);
         value = random_value();
         if (pick < 18)      cmd = OP_BYTE;
         else if (pick < 28) cmd = OP_BOOL;
         else if (pick < 46) cmd = OP_SHORT;
         else if (pick < 64) cmd = OP_LONG;
         else if (pick < 88) cmd = OP_LONGLONG;
         else if (pick < 95) cmd = OP_RESTART;
         else                cmd = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
         // booleans with a zero low byte but live upper bits
         if (cmd == OP_BOOL && $urandom_range(1) == 1)
            value[7:0] = 8'd0;
         send_beat(cmd, value);
         if (cmd != OP_UNUSED_LO && cmd != OP_UNUSED_HI)
            counted++;
         if ($urandom_range(39) == 0)
            wait_drained();
      end
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_stall, input int count);
      idle_pct = sender_idle;
      stall_pct <= receiver_stall;
      send_random(count);
      wait_drained();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      items_sent     = 0;
      unused_sent    = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: offsets noted after each beat
      send_beat(OP_BYTE,     64'h0000_0000_0000_0000);   // 1
      send_beat(OP_BYTE,     64'hFFFF_FFFF_FFFF_FFFF);   // 2
      send_beat(OP_BOOL,     64'hFFFF_FFFF_FFFF_FF00);   // 3, zero low byte
      send_beat(OP_BOOL,     64'h0000_0000_0000_0001);   // 4
      send_beat(OP_SHORT,    64'hFFFF_FFFF_FFFF_1234);   // 6, aligned
      send_beat(OP_BYTE,     64'h0000_0000_0000_00A5);   // 7
      send_beat(OP_SHORT,    64'h0000_0000_0000_FFFF);   // 2, one pad, wraps
      send_beat(OP_LONG,     64'h0000_0000_89AB_CDEF);   // 0, two pads
      send_beat(OP_LONGLONG, 64'h0123_4567_89AB_CDEF);   // 0, aligned
      send_beat(OP_BYTE,     64'h0000_0000_0000_0080);   // 1
      send_beat(OP_LONGLONG, 64'hFFFF_FFFF_FFFF_FFFF);   // 0, seven pads
      send_beat(OP_BOOL,     64'h0000_0000_0000_0080);   // 1
      send_beat(OP_LONG,     64'h0000_0000_0000_0000);   // 0, three pads
      send_beat(OP_BYTE,     64'h0000_0000_0000_0055);   // 1
      send_beat(OP_RESTART,  64'hFFFF_FFFF_FFFF_FFFF);   // 0, mid-stream
      send_beat(OP_LONG,     64'hFFFF_FFFF_8000_0001);   // 4, no pad
      send_beat(OP_UNUSED_LO, 64'hDEAD_BEEF_0000_00FF);  // dropped
      send_beat(OP_UNUSED_HI, 64'h0000_0000_0000_0000);  // dropped
      send_beat(OP_BYTE,     64'h0000_0000_0000_0001);   // 5
      send_beat(OP_SHORT,    64'h0000_0000_0000_8001);   // 0, one pad
      send_beat(OP_LONGLONG, 64'h0000_0000_0000_0000);   // 0, aligned
      wait_drained();

      run_phase(0,  0,  27);
      run_phase(46, 0,  27);
      run_phase(0,  46, 27);
      run_phase(27, 27, 27);

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d request beats (%0d with unused codes) in %0d cycles",
               items_sent, unused_sent, cycle_count);
      $display("checked %0d result beats, %0d of them alignment pad",
               byte_count, pad_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d beats missing", error_count, pending_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
